// ----- rtl/core/spas_pkg.sv -----
package spas_pkg;

   localparam int MaxTermsDef = 32;
   localparam int MaxResults  = 64;
   localparam int EmitW       = 7;

   typedef enum logic [2:0] {
      CMD_CLEAR    = 3'd0,
      CMD_APPEND_A = 3'd1,
      CMD_APPEND_B = 3'd2,
      CMD_PRINT    = 3'd3,
      CMD_ADD      = 3'd4,
      CMD_SUB      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_TERM = 2'd0,
      KIND_ZERO = 2'd1,
      KIND_DONE = 2'd2,
      KIND_OVER = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRINT_A,
      ST_PRINT_B,
      ST_FLUSH,
      ST_MERGE,
      ST_STATUS
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_CLEAR,
      OP_LOAD_A,
      OP_LOAD_B,
      OP_PRINT_A,
      OP_PRINT_B,
      OP_FLUSH,
      OP_MERGE,
      OP_STATUS
   } op_type;

   typedef struct packed {
      op_type op;
      logic   negate;
   } ctl_type;

   typedef struct packed {
      logic a_more;
      logic b_more;
      logic step_ok;
      logic pend_v;
   } sts_type;

endpackage

// ----- rtl/core/spas_ctrl.sv -----
module spas_ctrl import spas_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_cmd,
   input  sts_type    sts,
   output logic       req_ready,
   output ctl_type    ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      ctl.op     = OP_NONE;
      ctl.negate = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_CLEAR) begin
                  ctl.op   = OP_CLEAR;
                  state_in = ST_STATUS;
               end else if (req_cmd == CMD_APPEND_A) begin
                  ctl.op   = OP_LOAD_A;
                  state_in = ST_STATUS;
               end else if (req_cmd == CMD_APPEND_B) begin
                  ctl.op   = OP_LOAD_B;
                  state_in = ST_STATUS;
               end else if (req_cmd == CMD_PRINT) begin
                  ctl.op   = OP_START;
                  state_in = ST_PRINT_A;
               end else if (req_cmd == CMD_ADD || req_cmd == CMD_SUB) begin
                  ctl.op     = OP_START;
                  ctl.negate = (req_cmd == CMD_SUB);
                  state_in   = ST_MERGE;
               end else begin
                  ctl.op   = OP_START;
                  state_in = ST_STATUS;
               end
            end
         end
         ST_PRINT_A: begin
            ctl.op = OP_PRINT_A;
            if (!sts.a_more && sts.step_ok) state_in = ST_PRINT_B;
         end
         ST_PRINT_B: begin
            ctl.op = OP_PRINT_B;
            if (!sts.b_more && sts.step_ok) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            ctl.op = OP_FLUSH;
            if (sts.step_ok) state_in = ST_IDLE;
         end
         ST_MERGE: begin
            ctl.op = OP_MERGE;
            if (!sts.a_more && !sts.b_more) state_in = ST_STATUS;
         end
         ST_STATUS: begin
            ctl.op = OP_STATUS;
            if (sts.step_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/spas_dp.sv -----
module spas_dp import spas_pkg::*; #(
   parameter int MAX_TERMS = MaxTermsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   input  logic [31:0] term_coef,
   input  logic [31:0] term_expo,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic        rsp_which,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_coef,
   output logic [31:0] rsp_expo,
   output logic        rsp_last,
   output sts_type     sts
);

   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CW = $clog2(MAX_TERMS + 1);
   localparam logic [CW-1:0] MaxCnt = CW'(MAX_TERMS);

   // A is two banks: merge reads one and writes the other
   logic [63:0] a_mem [2 << AW];
   logic [63:0] b_mem [MAX_TERMS];

   logic [63:0]    rd_a_ff, rd_b_ff;
   logic           a_bank_ff, a_bank_in;
   logic [CW-1:0]  a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   logic [CW-1:0]  i_ff, i_in, j_ff, j_in, len_ff, len_in, kept_ff, kept_in;
   logic           ovf_ff, ovf_in, neg_ff, neg_in;
   logic [EmitW-1:0] emit_ff, emit_in;
   logic           pend_v_ff, pend_v_in, pend_which_ff, pend_which_in;
   logic [1:0]     pend_kind_ff, pend_kind_in;
   logic [31:0]    pend_coef_ff, pend_coef_in, pend_expo_ff, pend_expo_in;
   logic           rsp_valid_ff, rsp_valid_in, rsp_which_ff, rsp_which_in;
   logic [1:0]     rsp_kind_ff, rsp_kind_in;
   logic [31:0]    rsp_coef_ff, rsp_coef_in, rsp_expo_ff, rsp_expo_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           a_we, b_we;
   logic [AW:0]    a_waddr;
   logic [AW-1:0]  b_waddr;
   logic [63:0]    a_wdata, b_wdata;

   logic           a_more, b_more, out_free, want, emit_room, blocked, step_ok;
   logic           n_which;
   logic [1:0]     n_kind;
   logic [31:0]    n_coef, n_expo, bc;
   logic           a_lt, b_lt;

   always_ff @(posedge clock) begin
      if (a_we) a_mem[a_waddr] <= a_wdata;
      if (b_we) b_mem[b_waddr] <= b_wdata;
      rd_a_ff <= a_mem[{a_bank_ff, i_in[AW-1:0]}];
      rd_b_ff <= b_mem[j_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_cnt_ff     <= '0;
         b_cnt_ff     <= '0;
         a_bank_ff    <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_cnt_ff     <= a_cnt_in;
         b_cnt_ff     <= b_cnt_in;
         a_bank_ff    <= a_bank_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      len_ff        <= len_in;
      kept_ff       <= kept_in;
      ovf_ff        <= ovf_in;
      neg_ff        <= neg_in;
      emit_ff       <= emit_in;
      pend_which_ff <= pend_which_in;
      pend_kind_ff  <= pend_kind_in;
      pend_coef_ff  <= pend_coef_in;
      pend_expo_ff  <= pend_expo_in;
      rsp_which_ff  <= rsp_which_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_coef_ff   <= rsp_coef_in;
      rsp_expo_ff   <= rsp_expo_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // what a print step would emit, whether it must wait, and the merge compares
   always_comb begin
      a_more    = i_ff < a_cnt_ff;
      b_more    = j_ff < b_cnt_ff;
      out_free  = !rsp_valid_ff || rsp_ready;
      emit_room = emit_ff < EmitW'(MaxResults);
      want      = 1'b0;
      n_which   = 1'b0;
      n_kind    = KIND_TERM;
      n_coef    = rd_a_ff[31:0];
      n_expo    = rd_a_ff[63:32];
      if (ctl.op == OP_PRINT_A) begin
         if (a_more) begin
            want = (rd_a_ff[31:0] != '0);
         end else begin
            want   = (kept_ff == '0);
            n_kind = KIND_ZERO;
            n_coef = '0;
            n_expo = '0;
         end
      end else if (ctl.op == OP_PRINT_B) begin
         n_which = 1'b1;
         n_coef  = rd_b_ff[31:0];
         n_expo  = rd_b_ff[63:32];
         if (b_more) begin
            want = (rd_b_ff[31:0] != '0);
         end else begin
            want   = (kept_ff == '0);
            n_kind = KIND_ZERO;
            n_coef = '0;
            n_expo = '0;
         end
      end
      blocked = want && emit_room && pend_v_ff && !out_free;
      bc      = neg_ff ? (32'd0 - rd_b_ff[31:0]) : rd_b_ff[31:0];
      a_lt    = $signed(rd_a_ff[63:32]) < $signed(rd_b_ff[63:32]);
      b_lt    = $signed(rd_b_ff[63:32]) < $signed(rd_a_ff[63:32]);
   end

   always_comb begin
      a_bank_in     = a_bank_ff;
      a_cnt_in      = a_cnt_ff;
      b_cnt_in      = b_cnt_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      len_in        = len_ff;
      kept_in       = kept_ff;
      ovf_in        = ovf_ff;
      neg_in        = neg_ff;
      emit_in       = emit_ff;
      pend_v_in     = pend_v_ff;
      pend_which_in = pend_which_ff;
      pend_kind_in  = pend_kind_ff;
      pend_coef_in  = pend_coef_ff;
      pend_expo_in  = pend_expo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_which_in  = rsp_which_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_coef_in   = rsp_coef_ff;
      rsp_expo_in   = rsp_expo_ff;
      rsp_last_in   = rsp_last_ff;
      a_we          = 1'b0;
      a_waddr       = {a_bank_ff, kept_ff[AW-1:0]};
      a_wdata       = rd_a_ff;
      b_we          = 1'b0;
      b_waddr       = kept_ff[AW-1:0];
      b_wdata       = rd_b_ff;
      step_ok       = !blocked;

      // hold back one result so the final one can carry last
      if (want && emit_room && !blocked) begin
         if (pend_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_which_in = pend_which_ff;
            rsp_kind_in  = pend_kind_ff;
            rsp_coef_in  = pend_coef_ff;
            rsp_expo_in  = pend_expo_ff;
            rsp_last_in  = 1'b0;
         end
         pend_v_in     = 1'b1;
         pend_which_in = n_which;
         pend_kind_in  = n_kind;
         pend_coef_in  = n_coef;
         pend_expo_in  = n_expo;
         emit_in       = emit_ff + 1'b1;
      end

      unique case (ctl.op)
         OP_START: begin
            i_in      = '0;
            j_in      = '0;
            len_in    = '0;
            kept_in   = '0;
            ovf_in    = 1'b0;
            emit_in   = '0;
            pend_v_in = 1'b0;
            neg_in    = ctl.negate;
         end
         OP_CLEAR: begin
            a_cnt_in = '0;
            b_cnt_in = '0;
            ovf_in   = 1'b0;
         end
         OP_LOAD_A: begin
            a_waddr = {a_bank_ff, a_cnt_ff[AW-1:0]};
            a_wdata = {term_expo, term_coef};
            if (a_cnt_ff < MaxCnt) begin
               a_we     = 1'b1;
               a_cnt_in = a_cnt_ff + 1'b1;
               ovf_in   = 1'b0;
            end else begin
               ovf_in = 1'b1;
            end
         end
         OP_LOAD_B: begin
            b_waddr = b_cnt_ff[AW-1:0];
            b_wdata = {term_expo, term_coef};
            if (b_cnt_ff < MaxCnt) begin
               b_we     = 1'b1;
               b_cnt_in = b_cnt_ff + 1'b1;
               ovf_in   = 1'b0;
            end else begin
               ovf_in = 1'b1;
            end
         end
         OP_PRINT_A: begin
            if (!blocked) begin
               if (a_more) begin
                  if (rd_a_ff[31:0] != '0) begin
                     a_we    = 1'b1;
                     kept_in = kept_ff + 1'b1;
                  end
                  i_in = i_ff + 1'b1;
               end else begin
                  a_cnt_in = kept_ff;
                  kept_in  = '0;
               end
            end
         end
         OP_PRINT_B: begin
            if (!blocked) begin
               if (b_more) begin
                  if (rd_b_ff[31:0] != '0) begin
                     b_we    = 1'b1;
                     kept_in = kept_ff + 1'b1;
                  end
                  j_in = j_ff + 1'b1;
               end else begin
                  b_cnt_in = kept_ff;
                  kept_in  = '0;
               end
            end
         end
         OP_FLUSH: begin
            step_ok = out_free;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_which_in = pend_which_ff;
               rsp_kind_in  = pend_kind_ff;
               rsp_coef_in  = pend_coef_ff;
               rsp_expo_in  = pend_expo_ff;
               rsp_last_in  = 1'b1;
               pend_v_in    = 1'b0;
            end
         end
         OP_MERGE: begin
            a_waddr = {~a_bank_ff, len_ff[AW-1:0]};
            if (a_more || b_more) begin
               if (a_more && (!b_more || a_lt)) begin
                  a_wdata = rd_a_ff;
                  i_in    = i_ff + 1'b1;
               end else if (!a_more || b_lt) begin
                  a_wdata = {rd_b_ff[63:32], bc};
                  j_in    = j_ff + 1'b1;
               end else begin
                  a_wdata = {rd_a_ff[63:32], rd_a_ff[31:0] + bc};
                  i_in    = i_ff + 1'b1;
                  j_in    = j_ff + 1'b1;
               end
               if (len_ff < MaxCnt) begin
                  a_we   = 1'b1;
                  len_in = len_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               a_bank_in = ~a_bank_ff;
               a_cnt_in  = len_ff;
            end
         end
         OP_STATUS: begin
            step_ok = out_free;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_which_in = 1'b0;
               rsp_kind_in  = ovf_ff ? KIND_OVER : KIND_DONE;
               rsp_coef_in  = '0;
               rsp_expo_in  = '0;
               rsp_last_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign sts.a_more  = a_more;
   assign sts.b_more  = b_more;
   assign sts.step_ok = step_ok;
   assign sts.pend_v  = pend_v_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_which   = rsp_which_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_coef    = rsp_coef_ff;
   assign rsp_expo    = rsp_expo_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ----- rtl/core/sparse_polynomial_add_sub.sv -----
// Channel | Dir | Ports                        | Beat contents
// req     | in  | req_tvalid/tready/tdata/tuser | one command, with a term for appends
// rsp     | out | rsp_tvalid/tready/tdata/tuser/tlast | one term, marker or status
//
// Append and clear go through a status step; add/subtract run at most na + nb merge
// steps (one merge step per cycle through the term memories), then a status step; print
// walks A, then B, then flushes the held result. Each term memory has a single read port.
// Reset clears both list counts; term memories need no clearing pass.
// A stalled rsp side holds the walk at the next term to emit; one item is in work at a time.
module sparse_polynomial_add_sub import spas_pkg::*; #(
   parameter int MAX_TERMS = MaxTermsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // term_coef[31:0], term_expo[63:32]
   input  logic [2:0]  req_tuser,  // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // coef[31:0], expo[63:32]
   output logic [2:0]  rsp_tuser,  // which_poly[0], kind[2:1]
   output logic        rsp_tlast
);

   ctl_type     ctl;
   sts_type     sts;
   logic        which;
   logic [1:0]  kind;
   logic [31:0] coef, expo;

   spas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser),
      .sts       (sts),
      .req_ready (req_tready),
      .ctl       (ctl)
   );

   spas_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .term_coef (req_tdata[31:0]),
      .term_expo (req_tdata[63:32]),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_which (which),
      .rsp_kind  (kind),
      .rsp_coef  (coef),
      .rsp_expo  (expo),
      .rsp_last  (rsp_tlast),
      .sts       (sts)
   );

   assign rsp_tdata = {expo, coef};
   assign rsp_tuser = {kind, which};

`ifndef SYNTH
   // an accepted beat always starts work, so the block is busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready after accept");

   // no held-back print result may survive into idle
   a_no_pending_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.pend_v)
      else $error("pending result while idle");
`endif

endmodule
